FILE: sv/load_setpoint_protection_ctrl_core_macros.svh
// ----------------------------------------------------------------------------
// Load setpoint protection controller - assertion macros
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LOAD_SETPOINT_PROTECTION_CTRL_CORE_MACROS_SVH
`define LOAD_SETPOINT_PROTECTION_CTRL_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LSPC_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lspc assertion failed");
// next-cycle implication
`define LSPC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lspc assertion failed");
`else
`define LSPC_ASSERT_NOW(label, ck, rn, ante, cons)
`define LSPC_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

FILE: sv/lspc_pkg.sv
// ----------------------------------------------------------------------------
// Load setpoint protection controller - package
// Function, trip and register codes, and the divider request bundle.
// ----------------------------------------------------------------------------
package lspc_pkg;

    localparam int NCH        = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_SET  = 2'd1;
    localparam logic [1:0] FUNC_ON   = 2'd2;
    localparam logic [1:0] FUNC_OFF  = 2'd3;

    localparam logic [1:0] TRIP_NONE = 2'd0;
    localparam logic [1:0] TRIP_OC   = 2'd1;
    localparam logic [1:0] TRIP_OT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CH0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CH1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CH2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CH0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CH1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CH2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIM = 3'd6;

    localparam logic [15:0]        MAX_CURRENT_RST = 16'd10000;
    localparam logic signed [11:0] TEMP_LIMIT_RST  = 12'sd850;

    typedef struct packed {
        logic               start;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic [15:0]        target;
    } div_req_t;

endpackage

FILE: sv/lspc_code_div.sv
// ----------------------------------------------------------------------------
// Load setpoint protection controller - DAC code divider
// Rounded (target - B) * 65536 / M with saturation, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lspc_code_div #(
    parameter int DAC_MAX_CODE = 4095
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lspc_pkg::div_req_t                    req,
    output logic                                  done,
    output logic [$clog2(DAC_MAX_CODE+1)-1:0]     code
);
    import lspc_pkg::*;

    localparam int QW  = $clog2(DAC_MAX_CODE + 1);
    localparam int CW  = $clog2(QW);
    localparam int NW  = 50;
    localparam int DRW = 33;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_OVF  = 4'b0010,
        D_ITER = 4'b0100,
        D_DONE = 4'b1000
    } dstate_t;

    dstate_t            state_reg, state_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [DRW-1:0]     d2_reg, d2_next;
    logic [DRW-1:0]     p_reg, p_next;
    logic [QW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               sat_reg, sat_next;

    logic signed [33:0] diff;
    logic [33:0]        a_full;
    logic [32:0]        d_full;
    logic [NW-QW-1:0]   hi;
    logic               ovf;
    logic [DRW:0]       t;
    logic [DRW:0]       t_sub;
    logic               ge;
    logic               zero_res;

    assign diff     = $signed({18'd0, req.target})
                    - $signed({{2{req.intercept[31]}}, req.intercept});
    assign zero_res = (req.slope == 32'sd0) || (diff == 34'sd0)
                    || (diff[33] != req.slope[31]);
    assign a_full   = diff[33] ? (34'd0 - diff) : diff;
    assign d_full   = req.slope[31] ? (33'd0 - {1'b0, req.slope}) : {1'b0, req.slope};

    assign hi    = n_reg[NW-1:QW];
    assign ovf   = hi >= {{(NW-QW-DRW){1'b0}}, d2_reg};
    assign t     = {p_reg, lo_reg[QW-1]};
    assign ge    = t >= {1'b0, d2_reg};
    assign t_sub = t - {1'b0, d2_reg};

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d2_next    = d2_reg;
        p_next     = p_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    sat_next = 1'b0;
                    lo_next  = '0;
                    if (zero_res)
                    begin
                        state_next = D_DONE;
                    end
                    else
                    begin
                        n_next     = {1'b0, a_full[31:0], 17'd0} + {18'd0, d_full[31:0]};
                        d2_next    = {d_full[31:0], 1'b0};
                        state_next = D_OVF;
                    end
                end
            end
            D_OVF:
            begin
                if (ovf)
                begin
                    sat_next   = 1'b1;
                    state_next = D_DONE;
                end
                else
                begin
                    p_next     = hi[DRW-1:0];
                    lo_next    = n_reg[QW-1:0];
                    cnt_next   = CW'(QW - 1);
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                p_next   = ge ? t_sub[DRW-1:0] : t[DRW-1:0];
                lo_next  = {lo_reg[QW-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d2_reg  <= d2_next;
        p_reg   <= p_next;
        lo_reg  <= lo_next;
        cnt_reg <= cnt_next;
        sat_reg <= sat_next;
    end

    assign done = (state_reg == D_DONE);
    assign code = (sat_reg || (lo_reg > QW'(DAC_MAX_CODE))) ? QW'(DAC_MAX_CODE) : lo_reg;

endmodule

FILE: sv/load_setpoint_protection_ctrl_core.sv
// ----------------------------------------------------------------------------
// Load setpoint protection controller - top level
// Three-channel constant-current load control sharing one DAC, with
// overcurrent and overtemperature trip.
// ----------------------------------------------------------------------------
// One item is worked at a time. Tick while off, tick with trip, turn-off and
// items naming an invalid channel go from the input transfer straight to the
// finish state and then into the output register. Items that produce a new DAC
// code go through the start and wait states and the bit-serial divider, one
// quotient bit per cycle; a code that is zero by zero slope or by sign skips
// the divide steps, and a saturated code stops after the overflow check. The
// input is ready again in the cycle after the result is loaded, and a result
// that is not taken holds the next one back. A finished result sits in the
// output register while the next item is taken in.
module load_setpoint_protection_ctrl_core #(
    parameter int DAC_MAX_CODE = 4095,
    parameter int NUM_CHANNELS = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lspc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [1:0]                          channel,
    input  logic [15:0]                         target_ma,
    input  logic [15:0]                         measured_ma,
    input  logic                                measured_valid,
    input  logic signed [11:0]                  temperature,
    input  logic                                temperature_valid,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [11:0]                         dac_code,
    output logic                                dac_written,
    output logic [7:0]                          dac_high_byte,
    output logic [7:0]                          dac_low_byte,
    output logic                                load_on,
    output logic [1:0]                          active_channel,
    output logic [1:0]                          trip,
    output logic                                accepted
);
    import lspc_pkg::*;

    localparam int DW = $clog2(DAC_MAX_CODE + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;

    logic [63:0]        cal_reg [0:NCH-1];
    logic [63:0]        cal_next [0:NCH-1];
    logic [15:0]        maxi_reg [0:NCH-1];
    logic [15:0]        maxi_next [0:NCH-1];
    logic signed [11:0] tlim_reg, tlim_next;

    logic [15:0]        target_reg [0:NCH-1];
    logic [15:0]        target_next [0:NCH-1];
    logic               on_reg, on_next;
    logic [1:0]         act_reg, act_next;
    logic [DW-1:0]      dac_reg, dac_next;

    logic [1:0]         code_ch_reg, code_ch_next;
    logic [15:0]        code_tgt_reg, code_tgt_next;
    logic               res_written_reg, res_written_next;
    logic [1:0]         res_trip_reg, res_trip_next;
    logic               res_acc_reg, res_acc_next;

    logic               out_valid_reg, out_valid_next;
    logic [DW-1:0]      out_dac_reg, out_dac_next;
    logic               out_written_reg, out_written_next;
    logic               out_on_reg, out_on_next;
    logic [1:0]         out_act_reg, out_act_next;
    logic [1:0]         out_trip_reg, out_trip_next;
    logic               out_acc_reg, out_acc_next;

    logic               ch_ok;
    logic [1:0]         ch_idx;
    logic [15:0]        tgt_clamp;
    logic               over_current;
    logic               over_temp;
    div_req_t           div_req;
    logic               div_done;
    logic [DW-1:0]      div_code;
    logic [15:0]        dac_ext;

    assign ch_ok        = 32'(channel) < NUM_CHANNELS;
    assign ch_idx       = ch_ok ? channel : 2'd0;
    assign tgt_clamp    = (target_ma > maxi_reg[ch_idx]) ? maxi_reg[ch_idx] : target_ma;
    assign over_current = measured_valid && (measured_ma >= maxi_reg[act_reg]);
    assign over_temp    = temperature_valid && (temperature >= tlim_reg);

    // configuration writes
    always_comb
    begin
        cal_next  = cal_reg;
        maxi_next = maxi_reg;
        tlim_next = tlim_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAL_CH0:  cal_next[0]  = cfg_data;
                CFG_CAL_CH1:  cal_next[1]  = cfg_data;
                CFG_CAL_CH2:  cal_next[2]  = cfg_data;
                CFG_MAX_CH0:  maxi_next[0] = cfg_data[15:0];
                CFG_MAX_CH1:  maxi_next[1] = cfg_data[15:0];
                CFG_MAX_CH2:  maxi_next[2] = cfg_data[15:0];
                CFG_TEMP_LIM: tlim_next    = $signed(cfg_data[11:0]);
                default:      tlim_next    = tlim_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        target_next      = target_reg;
        on_next          = on_reg;
        act_next         = act_reg;
        dac_next         = dac_reg;
        code_ch_next     = code_ch_reg;
        code_tgt_next    = code_tgt_reg;
        res_written_next = res_written_reg;
        res_trip_next    = res_trip_reg;
        res_acc_next     = res_acc_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_dac_next     = out_dac_reg;
        out_written_next = out_written_reg;
        out_on_next      = out_on_reg;
        out_act_next     = out_act_reg;
        out_trip_next    = out_trip_reg;
        out_acc_next     = out_acc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_written_next = 1'b0;
                    res_trip_next    = TRIP_NONE;
                    res_acc_next     = 1'b1;
                    state_next       = S_FIN;
                    unique case (func)
                        FUNC_TICK:
                        begin
                            if (on_reg)
                            begin
                                res_written_next = 1'b1;
                                if (over_current || over_temp)
                                begin
                                    res_trip_next        = over_current ? TRIP_OC : TRIP_OT;
                                    dac_next             = '0;
                                    on_next              = 1'b0;
                                    target_next[act_reg] = 16'd0;
                                end
                                else
                                begin
                                    code_ch_next  = act_reg;
                                    code_tgt_next = target_reg[act_reg];
                                    state_next    = S_START;
                                end
                            end
                        end
                        FUNC_SET:
                        begin
                            if (!ch_ok)
                            begin
                                res_acc_next = 1'b0;
                            end
                            else
                            begin
                                res_written_next    = 1'b1;
                                target_next[ch_idx] = tgt_clamp;
                                on_next             = (tgt_clamp != 16'd0);
                                code_ch_next        = ch_idx;
                                code_tgt_next       = tgt_clamp;
                                state_next          = S_START;
                            end
                        end
                        FUNC_ON:
                        begin
                            if (!ch_ok)
                            begin
                                res_acc_next = 1'b0;
                            end
                            else
                            begin
                                res_written_next = 1'b1;
                                act_next         = ch_idx;
                                on_next          = 1'b1;
                                code_ch_next     = ch_idx;
                                code_tgt_next    = target_reg[ch_idx];
                                state_next       = S_START;
                            end
                        end
                        FUNC_OFF:
                        begin
                            res_written_next     = 1'b1;
                            dac_next             = '0;
                            on_next              = 1'b0;
                            target_next[act_reg] = 16'd0;
                        end
                    endcase
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    dac_next   = div_code;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_dac_next     = dac_reg;
                    out_written_next = res_written_reg;
                    out_on_next      = on_reg;
                    out_act_next     = act_reg;
                    out_trip_next    = res_trip_reg;
                    out_acc_next     = res_acc_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            on_reg        <= 1'b0;
            act_reg       <= 2'd0;
            dac_reg       <= '0;
            out_valid_reg <= 1'b0;
            tlim_reg      <= TEMP_LIMIT_RST;
            for (int i = 0; i < NCH; i++)
            begin
                cal_reg[i]    <= 64'd0;
                maxi_reg[i]   <= MAX_CURRENT_RST;
                target_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            on_reg        <= on_next;
            act_reg       <= act_next;
            dac_reg       <= dac_next;
            out_valid_reg <= out_valid_next;
            tlim_reg      <= tlim_next;
            cal_reg       <= cal_next;
            maxi_reg      <= maxi_next;
            target_reg    <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_ch_reg     <= code_ch_next;
        code_tgt_reg    <= code_tgt_next;
        res_written_reg <= res_written_next;
        res_trip_reg    <= res_trip_next;
        res_acc_reg     <= res_acc_next;
        out_dac_reg     <= out_dac_next;
        out_written_reg <= out_written_next;
        out_on_reg      <= out_on_next;
        out_act_reg     <= out_act_next;
        out_trip_reg    <= out_trip_next;
        out_acc_reg     <= out_acc_next;
    end

    assign div_req.start     = (state_reg == S_START);
    assign div_req.slope     = $signed(cal_reg[code_ch_reg][63:32]);
    assign div_req.intercept = $signed(cal_reg[code_ch_reg][31:0]);
    assign div_req.target    = code_tgt_reg;

    lspc_code_div #(
        .DAC_MAX_CODE (DAC_MAX_CODE)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .code  (div_code)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign dac_ext        = 16'(out_dac_reg);
    assign dac_code       = dac_ext[11:0];
    assign dac_high_byte  = dac_ext[11:4];
    assign dac_low_byte   = {dac_ext[3:0], 4'd0};
    assign dac_written    = out_written_reg;
    assign load_on        = out_on_reg;
    assign active_channel = out_act_reg;
    assign trip           = out_trip_reg;
    assign accepted       = out_acc_reg;

`include "load_setpoint_protection_ctrl_core_macros.svh"

    `LSPC_ASSERT_NOW(a_dac_in_range, clk, rst_n, 1'b1, dac_reg <= DW'(DAC_MAX_CODE))
    `LSPC_ASSERT_NOW(a_active_valid, clk, rst_n, 1'b1, 32'(act_reg) < NUM_CHANNELS)
    `LSPC_ASSERT_NOW(a_div_done_wait, clk, rst_n, div_done, state_reg == S_WAIT)
    `LSPC_ASSERT_NEXT(a_start_to_wait, clk, rst_n, state_reg == S_START, state_reg == S_WAIT)

endmodule

FILE: dv/lspc_setpoint_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load setpoint controller - result checker
// Watches the configuration port and both item channels, keeps its own copy
// of the channel targets, on flag, active channel and DAC code, predicts the
// result of each input transfer and compares it field by field with the
// result transfers in order.
// ----------------------------------------------------------------------------
module lspc_setpoint_checker #(
    parameter int DAC_MAX_CODE = 4095,
    parameter int NUM_CHANNELS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lspc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      func,
    input  logic [1:0]                      channel,
    input  logic [15:0]                     target_ma,
    input  logic [15:0]                     measured_ma,
    input  logic                            measured_valid,
    input  logic signed [11:0]              temperature,
    input  logic                            temperature_valid,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [11:0]                     dac_code,
    input  logic                            dac_written,
    input  logic [7:0]                      dac_high_byte,
    input  logic [7:0]                      dac_low_byte,
    input  logic                            load_on,
    input  logic [1:0]                      active_channel,
    input  logic [1:0]                      trip,
    input  logic                            accepted,
    output int                              errors,
    output int                              pending
);
    import lspc_pkg::*;

    typedef struct packed {
        logic [11:0] code;
        logic        written;
        logic [7:0]  high_byte;
        logic [7:0]  low_byte;
        logic        on;
        logic [1:0]  chan;
        logic [1:0]  trip_kind;
        logic        taken;
    } dac_result_t;

    logic [63:0]        cal_word [NCH];
    logic [15:0]        limit_ma [NCH];
    logic signed [11:0] temp_lim;

    logic [15:0] chan_target [NCH];
    logic        on_flag;
    logic [1:0]  sel;
    logic [11:0] dac;

    dac_result_t predicted_dac_results [$];

    function automatic logic [11:0] dac_code_for(int unsigned ch, logic [15:0] amps);
        logic signed [31:0] slope32;
        logic signed [31:0] icpt32;
        longint             m;
        longint             b;
        longint             num;
        longint unsigned    a;
        longint unsigned    d;
        longint unsigned    q;
        slope32 = cal_word[ch][63:32];
        icpt32  = cal_word[ch][31:0];
        m       = longint'(slope32);
        b       = longint'(icpt32);
        num     = (longint'(amps) - b) * 65536;
        if (m == 0 || num == 0)
            return 12'd0;
        if ((num < 0) != (m < 0))
            return 12'd0;
        a = (num < 0) ? -num : num;
        d = (m < 0) ? -m : m;
        q = ((a << 1) + d) / (d << 1);
        if (q > DAC_MAX_CODE)
            q = 64'(DAC_MAX_CODE);
        return q[11:0];
    endfunction

    function automatic void shut_off();
        dac     = 12'd0;
        on_flag = 1'b0;
        if (sel < NCH)
            chan_target[sel] = 16'd0;
    endfunction

    function automatic dac_result_t predict_dac_result(
        logic [1:0] f, logic [1:0] ch, logic [15:0] tgt, logic [15:0] meas,
        logic mv, logic signed [11:0] temp, logic tv);
        dac_result_t res;
        logic [15:0] amps;
        int unsigned a;
        logic        ch_ok;
        res.written   = 1'b0;
        res.trip_kind = TRIP_NONE;
        res.taken     = 1'b1;
        ch_ok = (ch < NUM_CHANNELS) && (ch < NCH);
        a     = (sel < NCH) ? 32'(sel) : 0;
        case (f)
            FUNC_TICK:
                if (on_flag) begin
                    if (mv && meas >= limit_ma[a]) begin
                        shut_off();
                        res.trip_kind = TRIP_OC;
                    end else if (tv && temp >= temp_lim) begin
                        shut_off();
                        res.trip_kind = TRIP_OT;
                    end else begin
                        dac = dac_code_for(a, chan_target[a]);
                    end
                    res.written = 1'b1;
                end
            FUNC_SET:
                if (!ch_ok) begin
                    res.taken = 1'b0;
                end else begin
                    amps = (tgt > limit_ma[ch]) ? limit_ma[ch] : tgt;
                    chan_target[ch] = amps;
                    dac         = dac_code_for(32'(ch), amps);
                    on_flag     = (amps != 16'd0);
                    res.written = 1'b1;
                end
            FUNC_ON:
                if (!ch_ok) begin
                    res.taken = 1'b0;
                end else begin
                    sel         = ch;
                    on_flag     = 1'b1;
                    dac         = dac_code_for(32'(ch), chan_target[ch]);
                    res.written = 1'b1;
                end
            default: begin
                shut_off();
                res.written = 1'b1;
            end
        endcase
        res.code      = dac;
        res.high_byte = dac[11:4];
        res.low_byte  = {dac[3:0], 4'b0000};
        res.on        = on_flag;
        res.chan      = sel;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            if (errors < 10)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                         $realtime, name, want, got);
            errors++;
        end
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n) begin
        dac_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                cal_word[i]    = 64'd0;
                limit_ma[i]    = MAX_CURRENT_RST;
                chan_target[i] = 16'd0;
            end
            temp_lim = TEMP_LIMIT_RST;
            on_flag  = 1'b0;
            sel      = 2'd0;
            dac      = 12'd0;
            predicted_dac_results.delete();
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CAL_CH0:  cal_word[0] = cfg_data;
                    CFG_CAL_CH1:  cal_word[1] = cfg_data;
                    CFG_CAL_CH2:  cal_word[2] = cfg_data;
                    CFG_MAX_CH0:  limit_ma[0] = cfg_data[15:0];
                    CFG_MAX_CH1:  limit_ma[1] = cfg_data[15:0];
                    CFG_MAX_CH2:  limit_ma[2] = cfg_data[15:0];
                    CFG_TEMP_LIM: temp_lim    = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (predicted_dac_results.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result transfer with nothing expected", $realtime);
                    errors++;
                end else begin
                    want = predicted_dac_results.pop_front();
                    check_field("dac_code", 16'(want.code), 16'(dac_code));
                    check_field("dac_written", 16'(want.written), 16'(dac_written));
                    check_field("dac_high_byte", 16'(want.high_byte), 16'(dac_high_byte));
                    check_field("dac_low_byte", 16'(want.low_byte), 16'(dac_low_byte));
                    check_field("load_on", 16'(want.on), 16'(load_on));
                    check_field("active_channel", 16'(want.chan), 16'(active_channel));
                    check_field("trip", 16'(want.trip_kind), 16'(trip));
                    check_field("accepted", 16'(want.taken), 16'(accepted));
                end
            end
            if (in_valid && in_ready)
                predicted_dac_results.push_back(predict_dac_result(
                    func, channel, target_ma, measured_ma, measured_valid,
                    temperature, temperature_valid));
            pending <= predicted_dac_results.size();
        end
    end

endmodule

FILE: dv/tb_load_setpoint_protection_ctrl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load setpoint controller - testbench top
// Drives a directed sequence of limit, rounding, trip and invalid-channel
// items, then random phases under changing calibration, limits and
// temperature threshold, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_load_setpoint_protection_ctrl_core;
    import lspc_pkg::*;

    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 163;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            func;
    logic [1:0]            channel;
    logic [15:0]           target_ma;
    logic [15:0]           measured_ma;
    logic                  measured_valid;
    logic signed [11:0]    temperature;
    logic                  temperature_valid;
    logic                  out_valid;
    logic                  out_ready;
    logic [11:0]           dac_code;
    logic                  dac_written;
    logic [7:0]            dac_high_byte;
    logic [7:0]            dac_low_byte;
    logic                  load_on;
    logic [1:0]            active_channel;
    logic [1:0]            trip;
    logic                  accepted;

    int   errors;
    int   pending;
    int   cycles = 0;
    int   stall_left = 0;
    logic send_calm = 1'b0;
    logic sink_calm = 1'b0;

    load_setpoint_protection_ctrl_core dut (.*);

    lspc_setpoint_checker result_check (.*);

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] pick_cal();
        logic [31:0] m;
        logic [31:0] b;
        case ($urandom_range(0, 9))
            0:       m = 32'd0;
            1:       m = 32'h7FFF_FFFF;
            2:       m = 32'h8000_0000;
            3:       m = $urandom;
            4, 5:    m = -$urandom_range(60000, 1500000);
            default: m = $urandom_range(60000, 1500000);
        endcase
        case ($urandom_range(0, 7))
            0:       b = 32'h7FFF_FFFF;
            1:       b = 32'h8000_0000;
            2:       b = $urandom;
            default: b = $urandom_range(0, 12000) - 2000;
        endcase
        return {m, b};
    endfunction

    function automatic logic [63:0] pick_limit();
        logic [15:0] lim;
        case ($urandom_range(0, 7))
            0:       lim = 16'd0;
            1:       lim = 16'hFFFF;
            2:       lim = 16'($urandom);
            default: lim = 16'($urandom_range(2000, 12000));
        endcase
        return {$urandom, 16'($urandom), lim};
    endfunction

    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_load_setpoint_protection_ctrl_core: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic [1:0] f, input logic [1:0] ch,
                             input logic [15:0] tgt, input logic [15:0] meas,
                             input logic mv, input logic signed [11:0] temp,
                             input logic tv);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        func              <= f;
        channel           <= ch;
        target_ma         <= tgt;
        measured_ma       <= meas;
        measured_valid    <= mv;
        temperature       <= temp;
        temperature_valid <= tv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // wait for every predicted result, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        logic [1:0]         f;
        logic [1:0]         ch;
        logic [15:0]        tgt;
        logic [15:0]        meas;
        logic               mv;
        logic               tv;
        logic signed [11:0] temp;
        logic [11:0]        tlim;
        int                 r;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_valid          = 1'b0;
        func              = FUNC_TICK;
        channel           = 2'd0;
        target_ma         = 16'd0;
        measured_ma       = 16'd0;
        measured_valid    = 1'b0;
        temperature       = 12'sd0;
        temperature_valid = 1'b0;
        out_ready         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero slope, 10 A limits
        send_item(FUNC_TICK, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1, 12'sd2000, 1'b1);
        send_item(FUNC_SET, 2'd3, 16'd100, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_ON, 2'd3, 16'd0, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_SET, 2'd0, 16'hFFFF, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_TICK, 2'd0, 16'd0, 16'd9999, 1'b1, 12'sd849, 1'b1);
        send_item(FUNC_TICK, 2'd0, 16'd0, 16'd10000, 1'b1, 12'sd0, 1'b0);
        send_item(FUNC_ON, 2'd1, 16'd0, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_TICK, 2'd0, 16'd0, 16'hFFFF, 1'b0, 12'sd850, 1'b1);
        send_item(FUNC_ON, 2'd2, 16'd0, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_TICK, 2'd0, 16'd0, 16'd10000, 1'b1, 12'sd2000, 1'b1);
        send_item(FUNC_SET, 2'd1, 16'd0, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_OFF, 2'd0, 16'd0, 16'd0, 1'b0, 12'sd0, 1'b0);
        drain();

        // unit slope, double slope for rounding, extreme negative slope
        write_reg(CFG_CAL_CH0, {32'h0001_0000, 32'h0000_0000});
        write_reg(CFG_CAL_CH1, {32'h0002_0000, 32'h0000_0000});
        write_reg(CFG_CAL_CH2, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(CFG_MAX_CH0, 64'h0000_0000_0000_FFFF);
        write_reg(CFG_MAX_CH1, 64'd10000);
        write_reg(CFG_MAX_CH2, 64'h0000_0000_0000_0000);
        write_reg(CFG_TEMP_LIM, {52'd0, 12'hDDA});
        write_reg(CFG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_SET, 2'd0, 16'd4095, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_SET, 2'd0, 16'd4096, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_SET, 2'd0, 16'hFFFF, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_SET, 2'd1, 16'd3, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_SET, 2'd1, 16'd1, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_SET, 2'd2, 16'd100, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_ON, 2'd2, 16'd0, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_TICK, 2'd0, 16'd0, 16'd0, 1'b1, 12'sd0, 1'b0);
        send_item(FUNC_ON, 2'd0, 16'd0, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_TICK, 2'd0, 16'd0, 16'hFFFF, 1'b0, -12'sd550, 1'b1);
        send_item(FUNC_ON, 2'd0, 16'd0, 16'd0, 1'b0, 12'sd0, 1'b0);
        send_item(FUNC_TICK, 2'd0, 16'd0, 16'hFFFF, 1'b0, 12'sd2000, 1'b0);
        drain();

        write_reg(CFG_CAL_CH0, {32'hFFFF_0000, 32'h0000_0000});
        write_reg(CFG_TEMP_LIM, {52'd0, 12'd2000});
        send_item(FUNC_SET, 2'd0, 16'd500, 16'd0, 1'b0, 12'sd0, 1'b0);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_reg(CFG_CAL_CH0, pick_cal());
            write_reg(CFG_CAL_CH1, pick_cal());
            write_reg(CFG_CAL_CH2, pick_cal());
            write_reg(CFG_MAX_CH0, pick_limit());
            write_reg(CFG_MAX_CH1, pick_limit());
            write_reg(CFG_MAX_CH2, pick_limit());
            case ($urandom_range(0, 5))
                0:       tlim = 12'hDDA;
                1:       tlim = 12'd2000;
                2:       tlim = 12'($urandom);
                default: tlim = 12'($urandom_range(0, 2550) - 550);
            endcase
            write_reg(CFG_TEMP_LIM, {$urandom, 20'($urandom), tlim});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, {$urandom, $urandom});
            send_calm = (phase % 4 == 2) || (phase % 4 == 3);
            sink_calm = (phase % 4 == 3);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 38)
                    f = FUNC_TICK;
                else if (r < 68)
                    f = FUNC_SET;
                else if (r < 90)
                    f = FUNC_ON;
                else
                    f = FUNC_OFF;
                ch = ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                case ($urandom_range(0, 7))
                    0:       tgt = 16'd0;
                    1:       tgt = 16'($urandom);
                    default: tgt = 16'($urandom_range(0, 12000));
                endcase
                meas = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 12000));
                mv   = ($urandom_range(0, 3) != 0);
                tv   = 1'($urandom_range(0, 1));
                temp = ($urandom_range(0, 15) == 0) ? 12'($urandom)
                                                    : 12'($urandom_range(0, 2550) - 550);
                send_item(f, ch, tgt, meas, mv, temp, tv);
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("tb_load_setpoint_protection_ctrl_core: done, clean");
        else
            $display("tb_load_setpoint_protection_ctrl_core: done, errors");
        $finish;
    end

endmodule
